@@ rtl/core/intel_hex_record_parser_macros.svh @@
// assertion macros shared by the hex record parser rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IHEX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ihex assertion failed");

// next-cycle implication, checked out of reset
`define IHEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ihex assertion failed");

`endif

@@ rtl/core/ihex_pkg.sv @@
// types and constants of the hex record parser
// no dependencies
package ihex_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_REC  = 3'b010,
    PH_GAP  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_SYNTAX   = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_TYPE     = 2'd2
  } err_e;

  // record type field values that the parser knows
  typedef enum logic [7:0] {
    REC_DATA     = 8'h00,
    REC_EOF      = 8'h01,
    REC_EXT_ADDR = 8'h04
  } rec_type_e;

  typedef struct packed {
    phase_e      phase;
    logic [8:0]  digit_count;
    logic [3:0]  high_nibble;
    logic [7:0]  record_length;
    logic [15:0] low_address;
    logic [7:0]  record_type;
    logic [7:0]  checksum_sum;
    logic [31:0] upper_address;
    logic [15:0] pending_upper;
    logic [31:0] current_address;
    logic [31:0] previous_address;
    logic        halted;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [31:0] fill_before;
    logic [7:0]  record_kind;
    err_e        error_code;
    logic        finished;
  } result_t;

  localparam state_t StateReset = '{phase: PH_WAIT, default: '0};
  localparam result_t ResultNone = '{kind: KIND_DATA, error_code: ERR_SYNTAX, default: '0};

endpackage

@@ rtl/core/ihex_if.sv @@
// valid/ready channels of the hex record parser: character in, result out
// no dependencies
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink (input valid, character, last_char, output ready);
endinterface

interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] byte_address;
  logic [31:0] fill_before;
  logic [7:0]  record_kind;
  logic [1:0]  error_code;
  logic        finished;

  modport source (output valid, kind, data_byte, byte_address, fill_before, record_kind,
                  error_code, finished, input ready);
  modport sink (input valid, kind, data_byte, byte_address, fill_before, record_kind,
                error_code, finished, output ready);
endinterface

@@ rtl/core/ihex_out_buf.sv @@
// two-word result buffer: output register plus skid register
// depends on ihex_pkg
module ihex_out_buf import ihex_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    can_take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop        = out_valid_q && out_ready_i;
  assign can_take_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && !pop) begin
      // output stalled, park a new word in the skid register
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = push_i;
      skid_d       = push_data_i;
    end else begin
      out_valid_d = push_i;
      out_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/ihex_step.sv @@
// next-state and result logic for one character of a hex file
// depends on ihex_pkg
module ihex_step import ihex_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] character_i,
  input  logic       last_char_i,
  output state_t     state_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [7:0] ChColon = 8'h3A;

  state_t      st;
  result_t     res;
  logic        has_res;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  rec_byte;
  logic [7:0]  idx;
  logic [8:0]  rec_end;
  logic [31:0] diff;
  logic [31:0] fill;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (character_i >= 8'h30 && character_i <= 8'h39) begin
      hex_val = character_i[3:0];
    end else if ((character_i >= 8'h41 && character_i <= 8'h46) ||
                 (character_i >= 8'h61 && character_i <= 8'h66)) begin
      hex_val = character_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign rec_byte = {state_i.high_nibble, hex_val};
  assign idx      = state_i.digit_count[8:1];
  assign rec_end  = {1'b0, state_i.record_length} + 9'd4;
  assign diff     = state_i.current_address - state_i.previous_address;
  assign fill     = (state_i.previous_address != '0 && diff[31:1] != '0) ? diff - 32'd1 : '0;

  always_comb begin
    st      = state_i;
    res     = ResultNone;
    has_res = 1'b0;
    if (!state_i.halted) begin
      unique case (state_i.phase)
        PH_WAIT, PH_GAP: begin
          if (character_i == ChColon) begin
            st.phase         = PH_REC;
            st.digit_count   = '0;
            st.high_nibble   = '0;
            st.record_length = '0;
            st.low_address   = '0;
            st.record_type   = '0;
            st.checksum_sum  = '0;
            st.pending_upper = '0;
          end else if (state_i.phase == PH_WAIT) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SYNTAX;
            has_res        = 1'b1;
            st.halted      = 1'b1;
          end
        end
        PH_REC: begin
          if (!hex_ok) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_SYNTAX;
            has_res        = 1'b1;
            st.halted      = 1'b1;
          end else if (!state_i.digit_count[0]) begin
            st.high_nibble = hex_val;
            st.digit_count = state_i.digit_count + 9'd1;
          end else begin
            st.digit_count = state_i.digit_count + 9'd1;
            if ({1'b0, idx} < rec_end) begin
              st.checksum_sum = state_i.checksum_sum - rec_byte;
            end
            if (idx == 8'd0) begin
              st.record_length = rec_byte;
            end else if (idx == 8'd1) begin
              st.low_address = {rec_byte, 8'h00};
            end else if (idx == 8'd2) begin
              st.low_address = {state_i.low_address[15:8], rec_byte};
            end else if (idx == 8'd3) begin
              st.record_type = rec_byte;
              if (rec_byte == REC_DATA) begin
                st.current_address = state_i.upper_address + {16'h0000, state_i.low_address};
              end
            end else if ({1'b0, idx} < rec_end) begin
              if (state_i.record_type == REC_DATA) begin
                res.kind            = KIND_DATA;
                res.data_byte       = rec_byte;
                res.byte_address    = state_i.current_address;
                res.fill_before     = fill;
                has_res             = 1'b1;
                st.previous_address = state_i.current_address;
                st.current_address  = state_i.current_address + 32'd1;
              end else if (state_i.record_type == REC_EXT_ADDR) begin
                if (idx == 8'd4) begin
                  st.pending_upper = {rec_byte, 8'h00};
                end else if (idx == 8'd5) begin
                  st.pending_upper = {state_i.pending_upper[15:8], rec_byte};
                end
              end
            end else begin
              // checksum byte closes the record
              st.phase = PH_GAP;
              has_res  = 1'b1;
              if (state_i.checksum_sum != rec_byte) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_CHECKSUM;
                st.halted      = 1'b1;
              end else if (state_i.record_type == REC_EXT_ADDR &&
                           state_i.record_length < 8'd2) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_SYNTAX;
                st.halted      = 1'b1;
              end else if (state_i.record_type != REC_DATA && state_i.record_type != REC_EOF &&
                           state_i.record_type != REC_EXT_ADDR) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TYPE;
                st.halted      = 1'b1;
              end else begin
                if (state_i.record_type == REC_EXT_ADDR) begin
                  st.upper_address   = {state_i.pending_upper, 16'h0000};
                  st.current_address = {state_i.pending_upper, state_i.low_address};
                end
                res.kind        = KIND_RECORD;
                res.record_kind = state_i.record_type;
              end
            end
          end
        end
        default: begin
          st = state_i;
        end
      endcase

      if (last_char_i) begin
        // end of file inside a record replaces whatever this character gave
        if (!st.halted && st.phase != PH_GAP) begin
          res            = ResultNone;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_SYNTAX;
          st.halted      = 1'b1;
        end else if (!has_res) begin
          res.kind = KIND_END;
        end
        res.finished = 1'b1;
        has_res      = 1'b1;
        if (!st.halted) begin
          st = StateReset;
        end
      end
    end
  end

  assign state_o     = st;
  assign res_valid_o = has_res;
  assign res_o       = res;

endmodule

@@ rtl/core/intel_hex_record_parser.sv @@
// Intel HEX record parser, one ASCII character per input word.
// in_i takes character and last_char; out_o gives at most one result word per
// character: a data byte with its 32-bit address and zero-fill count, an
// accepted record, an error, or the end of input.
// An accepted character updates the parser state in the same cycle; its result
// word goes to the output register, or to the skid register while out_o stalls.
// One character is taken every cycle while in_i.ready is high; each costs one
// nibble decode, an 8-bit checksum subtract and a 32-bit address add and subtract.
// After an error the parser halts: characters are still taken, but give no
// result until rst_ni; the receiver discards the whole file's output.
// After the last character of a good file the state returns to reset, so the
// next file may follow directly. Reset waits for the first colon.
// A stalled receiver: the output register holds its word and a skid register
// takes one more; in_i.ready falls only while both are full.
// Uses ihex_pkg, ihex_if, ihex_step, ihex_out_buf.
`include "intel_hex_record_parser_macros.svh"

module intel_hex_record_parser import ihex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ihex_in_if.sink   in_i,
  ihex_out_if.source out_o
);

  state_t  state_q, state_d;
  result_t res, out_data;
  logic    res_valid;
  logic    in_fire;
  logic    can_take;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = can_take;

  ihex_step u_step (
    .state_i     (state_q),
    .character_i (in_i.character),
    .last_char_i (in_i.last_char),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  ihex_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && res_valid),
    .push_data_i (res),
    .can_take_o  (can_take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.kind         = out_data.kind;
  assign out_o.data_byte    = out_data.data_byte;
  assign out_o.byte_address = out_data.byte_address;
  assign out_o.fill_before  = out_data.fill_before;
  assign out_o.record_kind  = out_data.record_kind;
  assign out_o.error_code   = out_data.error_code;
  assign out_o.finished     = out_data.finished;

  // a halted parser stays silent and stays halted
  `IHEX_ASSERT_IMPL(a_halted_silent, state_q.halted, !res_valid)
  `IHEX_ASSERT_NEXT(a_halted_sticky, state_q.halted, state_q.halted)
  // every last character of a live file gives a finished word
  `IHEX_ASSERT_IMPL(a_last_has_result, in_fire && in_i.last_char && !state_q.halted,
                    res_valid && res.finished)
  // end of input is only reported for the last character
  `IHEX_ASSERT_IMPL(a_end_on_last, res_valid && res.kind == KIND_END, in_i.last_char)

endmodule

@@ sim/intel_hex_record_parser_tb.sv @@
// self-checking testbench for the intel hex record parser: streams hex files one
// character per word and checks every result word against a cycle-free parser model
// depends on ihex_pkg, ihex_in_if / ihex_out_if and the intel_hex_record_parser rtl
module intel_hex_record_parser_tb import ihex_pkg::*; ();

  localparam logic [7:0] COLON         = 8'h3A;
  localparam logic [7:0] ASCII_CR      = 8'h0D;
  localparam logic [7:0] ASCII_LF      = 8'h0A;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;

  localparam int unsigned CHAR_TARGET = 1300;

  typedef struct {
    logic [7:0] character;
    logic       last_char;
    logic       hold;
  } char_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ihex_in_if  char_if ();
  ihex_out_if res_if ();

  intel_hex_record_parser u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_if),
    .out_o (res_if)
  );

  char_word_t  char_fifo[$];
  result_t     awaited_results[$];
  state_t      parser;
  int unsigned total_chars;
  int unsigned chars_taken;
  logic        word_taken;
  logic        failed;
  logic [15:0] addr_cursor;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parser model

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= ASCII_ZERO && c <= ASCII_ZERO + 8'd9) return int'(c - ASCII_ZERO);
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_A + 8'd5) return int'(c - ASCII_UPPER_A) + 10;
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_A + 8'd5) return int'(c - ASCII_LOWER_A) + 10;
    return -1;
  endfunction

  function automatic void open_record();
    parser.phase         = PH_REC;
    parser.digit_count   = '0;
    parser.high_nibble   = '0;
    parser.record_length = '0;
    parser.low_address   = '0;
    parser.record_type   = '0;
    parser.checksum_sum  = '0;
    parser.pending_upper = '0;
  endfunction

  function automatic void flag_error(input err_e code, output logic has_word,
                                     output result_t word);
    word            = ResultNone;
    word.kind       = KIND_ERROR;
    word.error_code = code;
    has_word        = 1'b1;
    parser.halted   = 1'b1;
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic last,
                                     output logic has_word, output result_t word);
    int          v;
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [8:0]  stop_idx;
    logic [31:0] span;
    has_word = 1'b0;
    word     = ResultNone;
    if (parser.halted) return;
    case (parser.phase)
      PH_WAIT: begin
        if (c == COLON) open_record();
        else flag_error(ERR_SYNTAX, has_word, word);
      end
      PH_GAP: begin
        if (c == COLON) open_record();
      end
      default: begin
        v = nibble_of(c);
        if (v < 0) begin
          flag_error(ERR_SYNTAX, has_word, word);
        end else if (!parser.digit_count[0]) begin
          parser.high_nibble = v[3:0];
          parser.digit_count = parser.digit_count + 9'd1;
        end else begin
          b        = {parser.high_nibble, v[3:0]};
          idx      = parser.digit_count[8:1];
          stop_idx = 9'd4 + {1'b0, parser.record_length};
          parser.digit_count = parser.digit_count + 9'd1;
          if ({1'b0, idx} < stop_idx) parser.checksum_sum = parser.checksum_sum - b;
          if (idx == 8'd0) begin
            parser.record_length = b;
          end else if (idx == 8'd1) begin
            parser.low_address = {b, 8'h00};
          end else if (idx == 8'd2) begin
            parser.low_address[7:0] = parser.low_address[7:0] | b;
          end else if (idx == 8'd3) begin
            parser.record_type = b;
            if (b == REC_DATA)
              parser.current_address = parser.upper_address + {16'h0, parser.low_address};
          end else if ({1'b0, idx} < stop_idx) begin
            if (parser.record_type == REC_DATA) begin
              // zero fill counts any jump, backward too, but only after a nonzero address
              span = parser.current_address - parser.previous_address;
              has_word          = 1'b1;
              word.kind         = KIND_DATA;
              word.data_byte    = b;
              word.byte_address = parser.current_address;
              word.fill_before  = (parser.previous_address != 0 && span > 1) ? span - 1 : '0;
              parser.previous_address = parser.current_address;
              parser.current_address  = parser.current_address + 32'd1;
            end else if (parser.record_type == REC_EXT_ADDR) begin
              if (idx == 8'd4) parser.pending_upper = {b, 8'h00};
              else if (idx == 8'd5) parser.pending_upper[7:0] = parser.pending_upper[7:0] | b;
            end
          end else begin
            parser.phase = PH_GAP;
            if (parser.checksum_sum != b) begin
              flag_error(ERR_CHECKSUM, has_word, word);
            end else if (parser.record_type == REC_EXT_ADDR && parser.record_length < 8'd2) begin
              flag_error(ERR_SYNTAX, has_word, word);
            end else if (parser.record_type != REC_DATA && parser.record_type != REC_EOF &&
                         parser.record_type != REC_EXT_ADDR) begin
              flag_error(ERR_TYPE, has_word, word);
            end else begin
              if (parser.record_type == REC_EXT_ADDR) begin
                parser.upper_address   = {parser.pending_upper, 16'h0000};
                parser.current_address = parser.upper_address + {16'h0, parser.low_address};
              end
              has_word         = 1'b1;
              word.kind        = KIND_RECORD;
              word.record_kind = parser.record_type;
            end
          end
        end
      end
    endcase
    if (last) begin
      // an unfinished record at end of file overrides any byte just completed
      if (!parser.halted && parser.phase != PH_GAP) begin
        flag_error(ERR_SYNTAX, has_word, word);
      end else if (!has_word) begin
        word.kind = KIND_END;
        has_word  = 1'b1;
      end
      word.finished = 1'b1;
      if (!parser.halted) parser = StateReset;
    end
  endfunction

  // ---------------------------------------------------------------- file builders

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ASCII_ZERO + 8'(n);
    return ($urandom_range(1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(n) - 8'd10;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last = 1'b0,
                           input logic hold = 1'b0);
    char_fifo.push_back('{character: c, last_char: last, hold: hold});
  endtask

  task automatic push_hex_byte(input logic [7:0] b, input logic last);
    push_char(hex_char(b[7:4]));
    push_char(hex_char(b[3:0]), last);
  endtask

  task automatic push_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] rec_type, input logic [15:0] upper,
                             input logic [7:0] cks_skew, input logic last, input logic hold);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    push_char(COLON, 1'b0, hold);
    push_hex_byte(len, 1'b0);
    push_hex_byte(addr[15:8], 1'b0);
    push_hex_byte(addr[7:0], 1'b0);
    push_hex_byte(rec_type, 1'b0);
    sum = len + addr[15:8] + addr[7:0] + rec_type;
    for (i = 0; i < len; i++) begin
      if (rec_type == REC_EXT_ADDR && i < 2) b = (i == 0) ? upper[15:8] : upper[7:0];
      else b = 8'($urandom_range(255));
      push_hex_byte(b, 1'b0);
      sum = sum + b;
    end
    b = 8'h00 - sum + cks_skew;
    push_hex_byte(b, last);
  endtask

  // junk between records: line breaks and anything but a colon
  task automatic push_gap(input int count, input logic last_at_end);
    logic [7:0] c;
    int         i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        c = $urandom_range(1) ? ASCII_CR : ASCII_LF;
      end else begin
        do c = 8'($urandom_range(255)); while (c == COLON);
      end
      push_char(c, last_at_end && i == count - 1);
    end
  endtask

  task automatic push_random_file(input logic hold, input logic big);
    int          nrec;
    int          r;
    int          p;
    logic        end_on_record;
    logic [7:0]  len;
    logic [7:0]  rec_type;
    logic [15:0] addr;
    logic [15:0] upper;
    nrec          = $urandom_range(1, 5);
    end_on_record = $urandom_range(1);
    for (r = 0; r < nrec; r++) begin
      if (r > 0) push_gap($urandom_range(0, 3), 1'b0);
      p     = $urandom_range(99);
      upper = '0;
      if (big && r == 0) begin
        // longest record whose checksum still fits the digit counter
        rec_type    = REC_DATA;
        len         = 8'd251;
        addr        = addr_cursor;
        addr_cursor = addr + 16'(len);
      end else if (p < 65) begin
        rec_type = REC_DATA;
        len      = ($urandom_range(9) == 0) ? 8'($urandom_range(17, 40))
                                            : 8'($urandom_range(0, 16));
        case ($urandom_range(3))
          0, 1: addr = addr_cursor;
          2: addr = 16'($urandom_range(16'hFFFF));
          default: addr = addr_cursor + 16'($urandom_range(0, 16)) - 16'd8;
        endcase
        addr_cursor = addr + 16'(len);
      end else if (p < 85) begin
        rec_type = REC_EXT_ADDR;
        len      = ($urandom_range(4) == 0) ? 8'($urandom_range(3, 5)) : 8'd2;
        case ($urandom_range(3))
          0: upper = 16'hFFFF;
          1: upper = 16'h0000;
          default: upper = 16'($urandom_range(16'hFFFF));
        endcase
        addr = 16'($urandom_range(16'hFFFF));
      end else begin
        rec_type = REC_EOF;
        len      = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
        addr     = $urandom_range(1) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
      end
      push_record(len, addr, rec_type, upper, 8'h00, end_on_record && r == nrec - 1,
                  hold && r == 0);
    end
    if (!end_on_record) push_gap($urandom_range(1, 3), 1'b1);
  endtask

  // one file that ends the parser's life: a single error, then characters it must ignore
  task automatic push_fatal_file();
    int         s;
    int         n;
    int         i;
    logic [7:0] c;
    logic [7:0] rt;
    s = $urandom_range(0, 8);
    if (s != 0 && s != 7) begin
      push_record(8'd1, 16'($urandom_range(16'hFFFF)), REC_DATA, '0, 8'h00, 1'b0, 1'b0);
      push_gap($urandom_range(0, 2), 1'b0);
    end
    case (s)
      0: begin
        do c = 8'($urandom_range(255)); while (c == COLON);
        push_char(c);
      end
      1: begin
        push_char(COLON);
        push_hex_byte(8'($urandom_range(255)), 1'b0);
        do c = 8'($urandom_range(255)); while (nibble_of(c) >= 0 || c == COLON);
        push_char(c);
      end
      2: begin
        push_char(COLON);
        push_char(hex_char(4'($urandom_range(15))));
        push_char(COLON);
      end
      3: begin
        push_record(8'($urandom_range(0, 4)), 16'($urandom_range(16'hFFFF)), REC_DATA, '0,
                    8'($urandom_range(1, 255)), 1'b0, 1'b0);
      end
      4: begin
        push_record(8'($urandom_range(0, 1)), 16'($urandom_range(16'hFFFF)), REC_EXT_ADDR,
                    16'hFFFF, 8'h00, 1'b0, 1'b0);
      end
      5: begin
        do rt = 8'($urandom_range(255));
        while (rt == REC_DATA || rt == REC_EOF || rt == REC_EXT_ADDR);
        push_record(8'($urandom_range(0, 3)), 16'($urandom_range(16'hFFFF)), rt, '0, 8'h00,
                    1'b0, 1'b0);
      end
      6: begin
        push_char(COLON);
        n = $urandom_range(1, 9);
        for (i = 0; i < n; i++) push_char(hex_char(4'($urandom_range(15))), i == n - 1);
      end
      7: begin
        do c = 8'($urandom_range(255)); while (c == COLON);
        push_char(c, 1'b1);
      end
      default: begin
        // too long for the digit counter, the record never closes normally
        push_record(8'($urandom_range(252, 255)), 16'($urandom_range(16'hFFFF)), REC_DATA,
                    '0, 8'h00, 1'b0, 1'b0);
      end
    endcase
    n = $urandom_range(2, 6);
    for (i = 0; i < n; i++) push_char(8'($urandom_range(255)), i == n - 1);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin : drive_chars
    int         send_idle;
    int         recv_idle;
    char_word_t nxt;
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
      res_if.ready  <= 1'b0;
    end else begin
      if (chars_taken < total_chars / 3) begin
        send_idle = 23;
        recv_idle = 65;
      end else if (chars_taken < 2 * total_chars / 3) begin
        send_idle = 65;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (!char_if.valid || word_taken) begin
        // a held word waits until every result in flight has come back
        if (char_fifo.size() != 0 && $urandom_range(99) >= send_idle &&
            !(char_fifo[0].hold && awaited_results.size() != 0)) begin
          nxt = char_fifo.pop_front();
          char_if.valid     <= 1'b1;
          char_if.character <= nxt.character;
          char_if.last_char <= nxt.last_char;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch_words
    logic    has_word;
    result_t word;
    result_t want;
    word_taken = rst_ni && char_if.valid && char_if.ready;
    if (word_taken) begin
      chars_taken++;
      parse_char(char_if.character, char_if.last_char, has_word, word);
      if (has_word) awaited_results.push_back(word);
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: kind %0d", res_if.kind);
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        if (res_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
          failed = 1'b1;
        end
        if (res_if.data_byte !== want.data_byte) begin
          $error("data_byte: expected %02h, got %02h", want.data_byte, res_if.data_byte);
          failed = 1'b1;
        end
        if (res_if.byte_address !== want.byte_address) begin
          $error("byte_address: expected %08h, got %08h", want.byte_address,
                 res_if.byte_address);
          failed = 1'b1;
        end
        if (res_if.fill_before !== want.fill_before) begin
          $error("fill_before: expected %08h, got %08h", want.fill_before, res_if.fill_before);
          failed = 1'b1;
        end
        if (res_if.record_kind !== want.record_kind) begin
          $error("record_kind: expected %02h, got %02h", want.record_kind, res_if.record_kind);
          failed = 1'b1;
        end
        if (res_if.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, res_if.error_code);
          failed = 1'b1;
        end
        if (res_if.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, res_if.finished);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int k;
    char_if.valid     = 1'b0;
    char_if.character = '0;
    char_if.last_char = 1'b0;
    res_if.ready      = 1'b0;
    word_taken        = 1'b0;
    chars_taken       = 0;
    failed            = 1'b0;
    parser            = StateReset;
    addr_cursor       = '0;

    // address extremes, 32-bit wrap, the zero-address fill exception, long extended record
    push_record(8'd0, 16'hFFFF, REC_DATA, '0, 8'h00, 1'b0, 1'b0);
    push_gap(2, 1'b0);
    push_record(8'd2, 16'h0000, REC_EXT_ADDR, 16'hFFFF, 8'h00, 1'b0, 1'b0);
    push_record(8'd3, 16'hFFFE, REC_DATA, '0, 8'h00, 1'b0, 1'b0);
    push_record(8'd1, 16'h0010, REC_DATA, '0, 8'h00, 1'b0, 1'b0);
    push_record(8'd3, 16'h1234, REC_EXT_ADDR, 16'h0000, 8'h00, 1'b0, 1'b0);
    push_record(8'd1, 16'h0100, REC_DATA, '0, 8'h00, 1'b0, 1'b0);
    push_record(8'd0, 16'h0000, REC_EOF, '0, 8'h00, 1'b0, 1'b0);
    push_gap(1, 1'b1);
    // file that ends on an end-of-file record carrying a byte
    push_record(8'd1, 16'h8000, REC_EOF, '0, 8'h00, 1'b1, 1'b0);

    k = 0;
    while (char_fifo.size() < CHAR_TARGET) begin
      push_random_file(k == 3 || $urandom_range(11) == 0, k == 5);
      k++;
    end
    push_fatal_file();
    total_chars = char_fifo.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (chars_taken != total_chars) @(negedge clk_i);
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (!failed) begin
      $display("intel_hex_record_parser_tb: PASS");
    end else begin
      $display("intel_hex_record_parser_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("intel_hex_record_parser_tb: FAIL");
    $finish;
  end

endmodule
